/* sv/base64_stream_decoder_top_macros.svh */
// Assertion macros for the base64 stream decoder.
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

`ifndef SYNTH

// The condition must hold at every clock edge outside reset.
`define B64D_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define B64D_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define B64D_ASSERT_ALWAYS(name, clk, rst_n, cond, msg)
`define B64D_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg)
`define B64D_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/b64d_pkg.sv */
package b64d_pkg;

	localparam int COUNT_BITS = 16;
	localparam int SHOW_W = COUNT_BITS + 16;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_PAD   = 8'h3d;

	localparam logic [5:0] DIG_PLUS  = 6'd62;
	localparam logic [5:0] DIG_SLASH = 6'd63;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  kind;
		logic [15:0] byte_count;
	} res_t;

	// One entry per accepted character that causes results.
	typedef struct packed {
		logic [1:0]      n_res;
		res_t [2:0]      res;
	} cmd_t;

	// Returns {valid, value} for a base64 digit.
	function automatic logic [6:0] digit_decode(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= 8'h41 && c <= 8'h5a) begin
			t = c - 8'h41;
			return {1'b1, t[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			t = c - 8'h47;
			return {1'b1, t[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c + 8'h04;
			return {1'b1, t[5:0]};
		end else if (c == CH_PLUS) begin
			return {1'b1, DIG_PLUS};
		end else if (c == CH_SLASH) begin
			return {1'b1, DIG_SLASH};
		end
		return 7'd0;
	endfunction

	function automatic count_t sat_inc(input count_t x);
		if (x == '1) begin
			return x;
		end
		return x + 1'b1;
	endfunction

	// The reported count is limited to 16 bits.
	function automatic logic [15:0] show_count(input count_t x);
		logic [SHOW_W-1:0] w;
		w = {16'b0, x};
		if (w > SHOW_W'(17'h0ffff)) begin
			return 16'hffff;
		end
		return w[15:0];
	endfunction

endpackage

/* sv/b64d_queue.sv */
module b64d_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64d_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output b64d_pkg::cmd_t  head,
	output logic            empty
);
	import b64d_pkg::*;

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   fill_q;

	assign full  = (fill_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* sv/b64d_front.sv */
module b64d_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,     // [7:0] char_in
	input  logic            q_full,
	output logic            push,
	output b64d_pkg::cmd_t  push_cmd
);
	import b64d_pkg::*;

	localparam logic [3:0] PH_START   = 4'd0;
	localparam logic [3:0] PH_PLUS    = 4'd1;
	localparam logic [3:0] PH_SKIPPED = 4'd2;
	localparam logic [3:0] PH_NEXT    = 4'd3;
	localparam logic [3:0] PH_D2      = 4'd4;
	localparam logic [3:0] PH_D3      = 4'd5;
	localparam logic [3:0] PH_D4      = 4'd6;
	localparam logic [3:0] PH_SWALLOW = 4'd7;

	logic [3:0]  phase_q, phase_d;
	logic [17:0] held_q, held_d;
	logic        pad3_q, pad3_d;
	count_t      count_q, count_d;

	logic        accept;
	logic [7:0]  c;
	logic [6:0]  dig;
	logic        dv;
	logic [5:0]  dval;
	logic        pad4;
	logic [5:0]  d4;
	logic [1:0]  nbytes;
	logic        fin;
	logic [1:0]  fin_kind;
	logic [7:0]  b0, b1, b2;
	count_t      c1, c2, c3, cnt_after;
	res_t        fin_res;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign c        = s_tdata;
	assign dig      = digit_decode(c);
	assign dv       = dig[6];
	assign dval     = dig[5:0];
	assign pad4     = (c == CH_PAD);
	assign d4       = pad4 ? 6'd0 : dval;

	assign b0 = {held_q[17:12], held_q[11:10]};
	assign b1 = {held_q[9:6], held_q[5:2]};
	assign b2 = {held_q[1:0], d4};

	assign c1 = sat_inc(count_q);
	assign c2 = sat_inc(c1);
	assign c3 = sat_inc(c2);

	always_comb begin
		phase_d  = phase_q;
		held_d   = held_q;
		pad3_d   = pad3_q;
		nbytes   = 2'd0;
		fin      = 1'b0;
		fin_kind = KIND_OK;
		case (phase_q)
			PH_START: begin
				if (c == CH_PLUS) begin
					held_d  = {DIG_PLUS, 12'd0};
					phase_d = PH_PLUS;
				end else if (c == CH_CR) begin
					fin = 1'b1;
				end else if (!dv) begin
					fin      = 1'b1;
					fin_kind = KIND_ERR;
				end else begin
					held_d  = {dval, 12'd0};
					phase_d = PH_D2;
				end
			end
			PH_PLUS: begin
				if (c == CH_SPACE) begin
					phase_d = PH_SKIPPED;
				end else if (!dv) begin
					fin      = 1'b1;
					fin_kind = KIND_ERR;
				end else begin
					held_d  = {DIG_PLUS, dval, 6'd0};
					phase_d = PH_D3;
				end
			end
			PH_SKIPPED: begin
				if (c == CH_CR) begin
					fin = 1'b1;
				end else if (!dv) begin
					fin      = 1'b1;
					fin_kind = KIND_ERR;
				end else begin
					held_d  = {dval, 12'd0};
					phase_d = PH_D2;
				end
			end
			PH_NEXT: begin
				if (c == CH_NUL || c == CH_CR) begin
					fin = 1'b1;
				end else if (!dv) begin
					fin      = 1'b1;
					fin_kind = KIND_ERR;
				end else begin
					held_d  = {dval, 12'd0};
					pad3_d  = 1'b0;
					phase_d = PH_D2;
				end
			end
			PH_D2: begin
				if (!dv) begin
					fin      = 1'b1;
					fin_kind = KIND_ERR;
				end else begin
					held_d  = {held_q[17:12], dval, 6'd0};
					phase_d = PH_D3;
				end
			end
			PH_D3: begin
				if (c == CH_PAD) begin
					held_d  = {held_q[17:6], 6'd0};
					pad3_d  = 1'b1;
					phase_d = PH_D4;
				end else if (!dv) begin
					fin      = 1'b1;
					fin_kind = KIND_ERR;
				end else begin
					held_d  = {held_q[17:6], dval};
					pad3_d  = 1'b0;
					phase_d = PH_D4;
				end
			end
			PH_D4: begin
				if (!pad4 && !dv) begin
					fin      = 1'b1;
					fin_kind = KIND_ERR;
				end else begin
					if (pad3_q) begin
						nbytes = 2'd1;
					end else if (pad4) begin
						nbytes = 2'd2;
					end else begin
						nbytes = 2'd3;
					end
					if (pad4) begin
						fin = 1'b1;
					end else begin
						phase_d = PH_NEXT;
					end
				end
			end
			default: begin
				// Everything up to the terminator is dropped.
				phase_d = PH_SWALLOW;
			end
		endcase
		if (fin) begin
			phase_d = PH_SWALLOW;
		end
		if ((fin || phase_q == PH_SWALLOW) && c == CH_NUL) begin
			phase_d = PH_START;
			held_d  = '0;
			pad3_d  = 1'b0;
		end
	end

	always_comb begin
		case (nbytes)
			2'd1:    cnt_after = c1;
			2'd2:    cnt_after = c2;
			2'd3:    cnt_after = c3;
			default: cnt_after = count_q;
		endcase
		count_d = cnt_after;
		if ((fin || phase_q == PH_SWALLOW) && c == CH_NUL) begin
			count_d = '0;
		end
	end

	always_comb begin
		fin_res.out_byte   = 8'd0;
		fin_res.kind       = fin_kind;
		fin_res.byte_count = show_count(cnt_after);

		push_cmd.n_res = nbytes + {1'b0, fin};

		push_cmd.res[0] = fin_res;
		if (nbytes != 2'd0) begin
			push_cmd.res[0].out_byte   = b0;
			push_cmd.res[0].kind       = KIND_BYTE;
			push_cmd.res[0].byte_count = show_count(c1);
		end
		push_cmd.res[1] = fin_res;
		if (nbytes[1]) begin
			push_cmd.res[1].out_byte   = b1;
			push_cmd.res[1].kind       = KIND_BYTE;
			push_cmd.res[1].byte_count = show_count(c2);
		end
		push_cmd.res[2] = fin_res;
		if (nbytes == 2'd3) begin
			push_cmd.res[2].out_byte   = b2;
			push_cmd.res[2].kind       = KIND_BYTE;
			push_cmd.res[2].byte_count = show_count(c3);
		end
	end

	assign push = accept && (nbytes != 2'd0 || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			held_q  <= '0;
			pad3_q  <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			pad3_q  <= pad3_d;
			count_q <= count_d;
		end
	end

endmodule

/* sv/b64d_back.sv */
module b64d_back (
	input  logic            clk,
	input  logic            arst_n,
	input  b64d_pkg::cmd_t  head,
	input  logic            q_empty,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [23:0]     m_tdata,     // [7:0] out_byte, [23:8] byte_count
	output logic [1:0]      m_tuser,     // [1:0] kind
	output logic            m_tlast      // run_last
);
	import b64d_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic       last_q;
	res_t       out_q;
	logic       load;
	logic       at_last;

	assign load    = !q_empty && (!valid_q || m_tready);
	assign at_last = (idx_q == head.n_res - 2'd1);
	assign pop     = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				last_q  <= at_last;
				idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= head.res[idx_q];
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {out_q.byte_count, out_q.out_byte};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = last_q;

endmodule

/* sv/base64_stream_decoder_top.sv */
// The first result of a character is written into the queue, then registered in the output
// register. Throughput: one character per cycle while the queue is not full; results leave
// at one per cycle through the output register while m_tready allows, and a four-entry queue
// between decoder and output absorbs groups of three. A character that causes no result is
// only accepted while the queue has a free slot, though it leaves no entry. Reset (arst_n
// low, asynchronous) returns to the start of a string with count zero and an empty queue.
`include "base64_stream_decoder_top_macros.svh"

module base64_stream_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] char_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,     // [7:0] out_byte, [23:8] byte_count
	output logic [1:0]  m_tuser,     // [1:0] kind
	output logic        m_tlast      // run_last
);
	import b64d_pkg::*;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	cmd_t push_cmd;
	cmd_t head;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (q_push),
		.push_cmd (push_cmd)
	);

	b64d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head),
		.empty    (q_empty)
	);

	b64d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`B64D_ASSERT_ALWAYS(a_queue_sane, clk, arst_n, !(q_full && q_empty), "queue full and empty")
	`B64D_ASSERT_IMPLIES(a_end_is_last, clk, arst_n, m_tvalid && m_tuser != KIND_BYTE, m_tlast, "end result not last")
	`B64D_ASSERT_IMPLIES(a_end_no_byte, clk, arst_n, m_tvalid && m_tuser != KIND_BYTE, m_tdata[7:0] == 8'd0, "end result carries a byte")
	`B64D_ASSERT_NEXT(a_push_shows, clk, arst_n, q_push, !q_empty, "pushed entry missing")

endmodule
